// ----- hdl/csx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_pkg: shared types, constants and functions of the cursor sprite expander
// Holds the register map, the configuration and result structures and the
// byte to 2-bit code expansion.
// ----------------------------------------------------------------------------
package csx_pkg;

  // Sprite store geometry. Offsets are byte offsets that wrap at the store size.
  localparam int STORE_BYTES   = 4096;
  localparam int OFFSET_W      = $clog2(STORE_BYTES);
  localparam int MAX_ROW_BYTES = 8;
  localparam int COL_W         = 3;
  localparam int WIDTH_W       = 4;
  localparam int STRIDE_W      = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_XOR_MODE    = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES   = 2'd1;
  localparam logic [1:0] REG_LINE_STRIDE = 2'd2;

  localparam logic [WIDTH_W-1:0]  ROW_BYTES_RST   = 4'd8;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 7'd16;

  // Two-bit pixel codes.
  localparam logic [1:0] CODE_CLEAR = 2'b00;
  localparam logic [1:0] CODE_BG    = 2'b01;
  localparam logic [1:0] CODE_FG    = 2'b10;

  typedef struct packed {
    logic                xor_mode;
    logic [WIDTH_W-1:0]  row_bytes;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic                has_result;
    logic [OFFSET_W-1:0] offset;
    logic [31:0]         data;
    logic                is_word;
  } result_t;

  // Expands eight pixels into eight 2-bit codes, pixel k in bits 2k+1..2k.
  function automatic logic [15:0] expand_byte(input logic [7:0] img,
                                              input logic [7:0] msk);
    logic [15:0] h;
    h = '0;
    for (int k = 0; k < 8; k++) begin
      if (!msk[k]) begin
        h[2*k +: 2] = CODE_CLEAR;
      end else if (img[k]) begin
        h[2*k +: 2] = CODE_FG;
      end else begin
        h[2*k +: 2] = CODE_BG;
      end
    end
    return h;
  endfunction

endpackage

// ----- hdl/csx_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_cfg_regs: configuration registers
// Holds combine mode, row width and line stride, written over the
// configuration channel.
// ----------------------------------------------------------------------------
module csx_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [6:0]            wr_data,
  output csx_pkg::cfg_t         cfg
);
  import csx_pkg::*;

  cfg_t cfg_r;

  // Register writes; an index beyond the map is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.xor_mode    <= 1'b0;
      cfg_r.row_bytes   <= ROW_BYTES_RST;
      cfg_r.line_stride <= LINE_STRIDE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_XOR_MODE:    cfg_r.xor_mode    <= wr_data[0];
        REG_ROW_BYTES:   cfg_r.row_bytes   <= wr_data[WIDTH_W-1:0];
        REG_LINE_STRIDE: cfg_r.line_stride <= wr_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/csx_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_packer: pixel expansion and write packing
// Expands one byte to sixteen code bits, pairs halfwords into words and
// tracks the column, the row base offset and the pending halfword.
// ----------------------------------------------------------------------------
module csx_packer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csx_pkg::cfg_t         cfg,
  input  logic [7:0]            image_byte,
  input  logic [7:0]            mask_byte,
  input  logic                  start_of_image,
  input  logic                  advance,
  output csx_pkg::result_t      res
);
  import csx_pkg::*;

  logic [COL_W-1:0]    column_r,  column_nxt;
  logic [OFFSET_W-1:0] row_base_r, row_base_nxt;
  logic [15:0]         held_r,    held_nxt;

  logic [COL_W-1:0]    col;
  logic [OFFSET_W-1:0] base;
  logic [15:0]         held;
  logic [WIDTH_W-1:0]  width;
  logic [7:0]          comb_byte;
  logic [15:0]         half;
  logic                row_end;

  // A new image restarts at column zero, offset zero, nothing pending.
  assign col  = start_of_image ? '0 : column_r;
  assign base = start_of_image ? '0 : row_base_r;
  assign held = start_of_image ? '0 : held_r;

  // Row width clamped to one through the maximum.
  always_comb begin
    if (cfg.row_bytes == '0) begin
      width = WIDTH_W'(1);
    end else if (cfg.row_bytes > WIDTH_W'(MAX_ROW_BYTES)) begin
      width = WIDTH_W'(MAX_ROW_BYTES);
    end else begin
      width = cfg.row_bytes;
    end
  end

  // Combine image with mask and expand to codes.
  assign comb_byte = cfg.xor_mode ? (image_byte ^ mask_byte) : (image_byte & mask_byte);
  assign half      = expand_byte(comb_byte, mask_byte);
  assign row_end   = ({1'b0, col} + WIDTH_W'(1)) >= width;

  // An odd column completes a word; an even column at row end writes a halfword.
  // Both cases land at the even-column byte offset, four bytes per column pair.
  always_comb begin
    res.has_result = col[0] | row_end;
    res.is_word    = col[0];
    res.offset     = base + OFFSET_W'({col[COL_W-1:1], 2'b00});
    res.data       = col[0] ? {half, held} : {16'h0000, half};
  end

  // Next state of the row tracking.
  always_comb begin
    held_nxt = res.has_result ? 16'h0000 : half;
    if (row_end) begin
      column_nxt   = '0;
      row_base_nxt = base + OFFSET_W'(cfg.line_stride);
    end else begin
      column_nxt   = col + COL_W'(1);
      row_base_nxt = base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_base_r <= '0;
      held_r     <= '0;
    end else if (advance) begin
      column_r   <= column_nxt;
      row_base_r <= row_base_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

// ----- hdl/cursor_sprite_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_sprite_expander: monochrome cursor to 2-bit sprite write packer
// Top level with input register, packer, result register and configuration.
// ----------------------------------------------------------------------------
// The block takes one image byte and one mask byte per transfer and turns
// them into 2-bit pixel codes, emitting a 32-bit write for every pair of
// bytes in a row and a 16-bit write for an odd last byte. It sustains one
// input transfer per clock while the input is not stalled: an item is held in
// the input register, is expanded and packed in a single pass, and its write
// is then loaded into the output register, which drives out_valid. The
// input stalls only while the output register holds a write that is not
// taken and the item in the input register also produces a write.
// Configuration writes are accepted every cycle and must only be issued
// while the block is idle.
module cursor_sprite_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_image_byte,
  input  logic [7:0]  in_mask_byte,
  input  logic        in_start_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_write_offset,
  output logic [31:0] out_write_data,
  output logic        out_write_is_word
);
  import csx_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic        s0_valid_r;
  logic [7:0]  s0_image_r;
  logic [7:0]  s0_mask_r;
  logic        s0_sof_r;
  logic        s0_go;
  logic        in_xfer;
  logic        out_xfer;

  logic                out_valid_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [31:0]         out_data_r;
  logic                out_is_word_r;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  csx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on when it makes no write or the output slot frees.
  assign out_xfer = out_valid_r & ~out_stall;
  assign s0_go    = s0_valid_r & (~res.has_result | ~out_valid_r | ~out_stall);
  assign in_stall = s0_valid_r & ~s0_go;
  assign in_xfer  = in_valid & ~in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s0_valid_r <= 1'b1;
    end else if (s0_go) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_image_r <= in_image_byte;
      s0_mask_r  <= in_mask_byte;
      s0_sof_r   <= in_start_of_image;
    end
  end

  csx_packer u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .image_byte     (s0_image_r),
    .mask_byte      (s0_mask_r),
    .start_of_image (s0_sof_r),
    .advance        (s0_go),
    .res            (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_go && res.has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && res.has_result) begin
      out_offset_r  <= res.offset;
      out_data_r    <= res.data;
      out_is_word_r <= res.is_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_offset  = out_offset_r;
  assign out_write_data    = out_data_r;
  assign out_write_is_word = out_is_word_r;

  // A write never overwrites one that is still waiting downstream.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (s0_go && res.has_result) |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // A row-end halfword carries zeros in its upper half.
  a_half_upper_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_word_r) |-> (out_data_r[31:16] == 16'h0000))
    else $error("halfword write with nonzero upper half");

  // The input stalls only while an item is held.
  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

endmodule
